FILE: design/rtd_temperature_alarm_monitor_defines.svh
// Assertion helpers for the RTD monitor, clocked on i_clk, off during reset.
`ifndef RTD_TEMPERATURE_ALARM_MONITOR_DEFINES_SVH
`define RTD_TEMPERATURE_ALARM_MONITOR_DEFINES_SVH

// Same-cycle implication.
`define RTDTAM_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define RTDTAM_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: design/rtdtam_pkg.sv
package rtdtam_pkg;

    localparam int CHANNELS_DEF = 4;

    // Callendar-Van Dusen threshold, common factors removed:
    //   code * LHS_SCALE >= 8 * (POLY_ONE + POLY_A*k - POLY_B*k^2)
    localparam logic [29:0] POLY_ONE  = 30'd400000000;
    localparam logic [20:0] POLY_A    = 21'd1563320;
    localparam logic [7:0]  POLY_B    = 8'd231;
    localparam logic [18:0] LHS_SCALE = 19'd390625;

    localparam logic [31:0] ALARM_LIMITS_RST = 32'h6464_6464;
    localparam logic [31:0] TRIP_LIMITS_RST  = 32'h6E6E_6E6E;
    localparam logic [31:0] DELAYS_RST       = 32'h0000_0000;
    localparam logic [3:0]  ENABLE_MASK_RST  = 4'h0;

    typedef enum logic [1:0] {
        CFG_ALARM_LIMITS = 2'd0,
        CFG_TRIP_LIMITS  = 2'd1,
        CFG_DELAYS       = 2'd2,
        CFG_ENABLE_MASK  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LHS,
        S_SQ,
        S_CMP,
        S_UPD
    } t_state;

endpackage

FILE: design/rtd_temperature_alarm_monitor.sv
// Channel  | Dir | Handshake          | Beat payload
// ---------+-----+--------------------+-----------------------------------------------
// input    | in  | i_valid / o_ready  | action, channel, fault_byte, code_high/low
// result   | out | o_valid / i_ready  | report_channel, temperature, alarm, trip,
//          |     |                    | fault_code, out_of_range
// config   | in  | i_cfg_we           | i_cfg_index, i_cfg_data
//
// A clean sample goes from idle to S_LHS for the scaled code product, then
// through 8 bits of root search, each a square (S_SQ) and then a polynomial
// compare (S_CMP) through one shared datapath, then to the update state S_UPD,
// which sets o_valid. Clear actions, faulted samples (fault byte or code
// fault bit) and unused channels go from idle straight to S_UPD.
// Reset (synchronous, active low) loads register defaults and clears the FSM,
// channel state and o_valid. The next beat is taken while a result waits; the
// update stalls until the result register is free.
`include "rtd_temperature_alarm_monitor_defines.svh"

module rtd_temperature_alarm_monitor #(
    parameter int CHANNELS = rtdtam_pkg::CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [1:0]  i_channel,
    input  logic [7:0]  i_fault_byte,
    input  logic [7:0]  i_code_high,
    input  logic [7:0]  i_code_low,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_report_channel,
    output logic [7:0]  o_temperature,
    output logic        o_alarm,
    output logic        o_trip,
    output logic [7:0]  o_fault_code,
    output logic        o_out_of_range
);
    import rtdtam_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_state r_state, n_state;

    logic [31:0] r_alarm_lim, r_trip_lim, r_delays;
    logic [3:0]  r_enable;

    logic        r_action, r_cfb;
    logic [1:0]  r_ch;
    logic [7:0]  r_fault;
    logic [14:0] r_code;
    logic [33:0] r_lhs;
    logic [15:0] r_sq;
    logic [7:0]  r_t;
    logic [2:0]  r_bit;

    logic [7:0] r_temp  [CHANNELS];
    logic [7:0] r_acnt  [CHANNELS];
    logic [7:0] r_tcnt  [CHANNELS];
    logic [7:0] r_fstore[CHANNELS];
    logic       r_alat  [CHANNELS];
    logic       r_tlat  [CHANNELS];
    logic       r_range [CHANNELS];

    logic [7:0] n_temp  [CHANNELS];
    logic [7:0] n_acnt  [CHANNELS];
    logic [7:0] n_tcnt  [CHANNELS];
    logic [7:0] n_fstore[CHANNELS];
    logic       n_alat  [CHANNELS];
    logic       n_tlat  [CHANNELS];
    logic       n_range [CHANNELS];

    logic        r_out_valid;
    logic [1:0]  r_out_ch;
    logic [7:0]  r_out_temp, r_out_fault;
    logic        r_out_alarm, r_out_trip, r_out_range;

    logic          w_accept, w_upd, w_chv, w_en, w_hit;
    logic [CW-1:0] w_idx;
    logic [7:0]    w_k, w_alim, w_tlim, w_dly;
    logic [28:0]   w_ak;
    logic [23:0]   w_bsq;
    logic [29:0]   w_poly;
    logic [33:0]   w_rhs;

    assign w_accept = i_valid && o_ready;
    assign w_idx    = CW'(r_ch);
    assign w_chv    = 32'(r_ch) < CHANNELS;
    assign w_en     = w_chv && r_enable[r_ch];
    assign w_alim   = r_alarm_lim[{r_ch, 3'b000} +: 8];
    assign w_tlim   = r_trip_lim[{r_ch, 3'b000} +: 8];
    assign w_dly    = r_delays[{r_ch, 3'b000} +: 8];

    // root search datapath: candidate, polynomial, threshold compare
    assign w_k    = r_t | (8'd1 << r_bit);
    assign w_ak   = 29'(POLY_A) * 29'(w_k);
    assign w_bsq  = 24'(POLY_B) * 24'(r_sq);
    assign w_poly = POLY_ONE + 30'(w_ak) - 30'(w_bsq);
    assign w_rhs  = {1'b0, w_poly, 3'b000};
    assign w_hit  = r_lhs >= w_rhs;

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        w_upd   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_action || (i_fault_byte != 8'd0) || i_code_low[0]
                        || !(32'(i_channel) < CHANNELS)) begin
                        n_state = S_UPD;
                    end else begin
                        n_state = S_LHS;
                    end
                end
            end
            S_LHS: n_state = S_SQ;
            S_SQ:  n_state = S_CMP;
            S_CMP: n_state = (r_bit == 3'd0) ? S_UPD : S_SQ;
            S_UPD: begin
                if (!r_out_valid || i_ready) begin
                    w_upd   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // channel state after this beat
    always_comb begin
        n_temp   = r_temp;
        n_acnt   = r_acnt;
        n_tcnt   = r_tcnt;
        n_fstore = r_fstore;
        n_alat   = r_alat;
        n_tlat   = r_tlat;
        n_range  = r_range;
        if (r_action) begin
            for (int i = 0; i < CHANNELS; i++) begin
                n_alat[i] = 1'b0;
                n_tlat[i] = 1'b0;
            end
        end else if (w_chv) begin
            if (r_fault != 8'd0) begin
                n_temp[w_idx]   = 8'd0;
                n_fstore[w_idx] = r_fault;
            end else begin
                n_range[w_idx]  = r_cfb;
                n_temp[w_idx]   = r_t;
                n_fstore[w_idx] = 8'd0;
                if (r_t >= w_alim) begin
                    if (r_acnt[w_idx] < w_dly) begin
                        n_acnt[w_idx] = r_acnt[w_idx] + 8'd1;
                    end else begin
                        n_acnt[w_idx] = 8'd0;
                        n_alat[w_idx] = 1'b1;
                    end
                end else begin
                    n_acnt[w_idx] = 8'd0;
                end
                if (r_t >= w_tlim) begin
                    if (r_tcnt[w_idx] < w_dly) begin
                        n_tcnt[w_idx] = r_tcnt[w_idx] + 8'd1;
                    end else begin
                        n_tcnt[w_idx] = 8'd0;
                        n_tlat[w_idx] = 1'b1;
                    end
                end else begin
                    n_tcnt[w_idx] = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_lim <= ALARM_LIMITS_RST;
            r_trip_lim  <= TRIP_LIMITS_RST;
            r_delays    <= DELAYS_RST;
            r_enable    <= ENABLE_MASK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALARM_LIMITS: r_alarm_lim <= i_cfg_data;
                CFG_TRIP_LIMITS:  r_trip_lim  <= i_cfg_data;
                CFG_DELAYS:       r_delays    <= i_cfg_data;
                CFG_ENABLE_MASK:  r_enable    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_ch     <= i_channel;
            r_fault  <= i_fault_byte;
            r_code   <= {i_code_high, i_code_low[7:1]};
            r_cfb    <= i_code_low[0];
            r_t      <= 8'd0;
            r_bit    <= 3'd7;
        end
        if (r_state == S_LHS) begin
            r_lhs <= 34'(r_code) * 34'(LHS_SCALE);
        end
        if (r_state == S_SQ) begin
            r_sq <= 16'(w_k) * 16'(w_k);
        end
        if (r_state == S_CMP) begin
            if (w_hit) begin
                r_t <= w_k;
            end
            r_bit <= r_bit - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_temp[i]   <= 8'd0;
                r_acnt[i]   <= 8'd0;
                r_tcnt[i]   <= 8'd0;
                r_fstore[i] <= 8'd0;
                r_alat[i]   <= 1'b0;
                r_tlat[i]   <= 1'b0;
                r_range[i]  <= 1'b0;
            end
        end else if (w_upd) begin
            r_temp   <= n_temp;
            r_acnt   <= n_acnt;
            r_tcnt   <= n_tcnt;
            r_fstore <= n_fstore;
            r_alat   <= n_alat;
            r_tlat   <= n_tlat;
            r_range  <= n_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_upd) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_out_ch    <= r_ch;
            r_out_temp  <= w_en ? n_temp[w_idx]   : 8'd0;
            r_out_fault <= w_en ? n_fstore[w_idx] : 8'd0;
            r_out_alarm <= w_en && n_alat[w_idx];
            r_out_trip  <= w_en && n_tlat[w_idx];
            r_out_range <= w_en && n_range[w_idx];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_report_channel = r_out_ch;
    assign o_temperature    = r_out_temp;
    assign o_fault_code     = r_out_fault;
    assign o_alarm          = r_out_alarm;
    assign o_trip           = r_out_trip;
    assign o_out_of_range   = r_out_range;

    `RTDTAM_ASSERT_NEXT(a_busy_after_accept, w_accept, !o_ready, "ready high right after accept")
    `RTDTAM_ASSERT_IMPL(a_masked_temp, o_valid && (o_temperature != 8'd0), r_enable[o_report_channel], "temperature reported for disabled channel")
    `RTDTAM_ASSERT_IMPL(a_range_zero_temp, o_valid && o_out_of_range, o_temperature == 8'd0, "out of range with nonzero temperature")

endmodule

FILE: test/rtd_temperature_alarm_monitor_tb.sv
module rtd_temperature_alarm_monitor_tb;
    import rtdtam_pkg::*;

    localparam int NCH = 4;

    // Callendar-Van Dusen threshold terms, scaled by 1e10
    localparam longint unsigned CVD_ONE   = 64'd10000000000;
    localparam longint unsigned CVD_A     = 64'd39083000;
    localparam longint unsigned CVD_B     = 64'd5775;
    localparam longint unsigned CVD_SCALE = 64'd8192;

    typedef struct packed {
        logic [1:0] ch;
        logic [7:0] temp;
        logic       alarm;
        logic       trip;
        logic [7:0] fault;
        logic       oor;
    } t_status;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_ALARM_LIMITS;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_action = 1'b0;
    logic [1:0]  i_channel = '0;
    logic [7:0]  i_fault_byte = '0;
    logic [7:0]  i_code_high = '0;
    logic [7:0]  i_code_low = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_report_channel;
    logic [7:0]  o_temperature;
    logic        o_alarm;
    logic        o_trip;
    logic [7:0]  o_fault_code;
    logic        o_out_of_range;

    rtd_temperature_alarm_monitor dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_channel        (i_channel),
        .i_fault_byte     (i_fault_byte),
        .i_code_high      (i_code_high),
        .i_code_low       (i_code_low),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_report_channel (o_report_channel),
        .o_temperature    (o_temperature),
        .o_alarm          (o_alarm),
        .o_trip           (o_trip),
        .o_fault_code     (o_fault_code),
        .o_out_of_range   (o_out_of_range)
    );

    // Shadow registers and channel state of the monitor
    logic [31:0] sh_alarm = ALARM_LIMITS_RST;
    logic [31:0] sh_trip  = TRIP_LIMITS_RST;
    logic [31:0] sh_delay = DELAYS_RST;
    logic [3:0]  sh_en    = ENABLE_MASK_RST;
    logic [7:0]  m_temp   [NCH] = '{default: '0};
    logic [7:0]  m_acnt   [NCH] = '{default: '0};
    logic [7:0]  m_tcnt   [NCH] = '{default: '0};
    logic [7:0]  m_fault  [NCH] = '{default: '0};
    logic        m_alatch [NCH] = '{default: 1'b0};
    logic        m_tlatch [NCH] = '{default: 1'b0};
    logic        m_range  [NCH] = '{default: 1'b0};

    t_status status_q[$];
    int      err_count = 0;
    bit      src_idle = 1'b1;
    bit      sink_idle = 1'b1;
    int      sink_wait = 0;
    logic    hold_on = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

    function automatic bit cvd_reaches(longint unsigned code, longint unsigned k);
        longint unsigned poly;
        poly = CVD_ONE + CVD_A * k - CVD_B * k * k;
        return code * CVD_ONE >= CVD_SCALE * poly;
    endfunction

    // floor of the root, found bit by bit from the top
    function automatic logic [7:0] cvd_temp(logic [14:0] code);
        logic [7:0] t;
        t = '0;
        for (int b = 7; b >= 0; b--) begin
            if (cvd_reaches(64'(code), 64'(t | (8'd1 << b))))
                t = t | (8'd1 << b);
        end
        return t;
    endfunction

    // smallest code that linearizes to at least t
    function automatic logic [14:0] code_for_temp(logic [7:0] t);
        longint unsigned k, poly, code;
        k = 64'(t);
        poly = CVD_ONE + CVD_A * k - CVD_B * k * k;
        code = (CVD_SCALE * poly + CVD_ONE - 1) / CVD_ONE;
        return code[14:0];
    endfunction

    function automatic string show_status(t_status s);
        return $sformatf("ch=%0d temp=%0d alarm=%0b trip=%0b fault=%02h oor=%0b",
                         s.ch, s.temp, s.alarm, s.trip, s.fault, s.oor);
    endfunction

    task automatic log_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic qualify(input logic [7:0] t, input logic [7:0] lim,
                           input logic [7:0] dly, inout logic [7:0] cnt,
                           inout logic latch);
        if (t >= lim) begin
            if (cnt < dly) begin
                cnt = cnt + 8'd1;
            end else begin
                cnt = '0;
                latch = 1'b1;
            end
        end else begin
            cnt = '0;
        end
    endtask

    task automatic apply_sample(input bit act, input logic [1:0] ch,
                                input logic [7:0] fs, input logic [14:0] code,
                                input bit fbit, output t_status st);
        logic [7:0] t;
        logic       en;
        if (act) begin
            for (int i = 0; i < NCH; i++) begin
                m_alatch[i] = 1'b0;
                m_tlatch[i] = 1'b0;
            end
        end else if (fs != 8'd0) begin
            m_temp[ch] = '0;
            m_fault[ch] = fs;
        end else begin
            if (fbit) begin
                m_range[ch] = 1'b1;
                t = '0;
            end else begin
                m_range[ch] = 1'b0;
                t = cvd_temp(code);
            end
            m_temp[ch] = t;
            m_fault[ch] = '0;
            qualify(t, sh_alarm[8*ch +: 8], sh_delay[8*ch +: 8], m_acnt[ch], m_alatch[ch]);
            qualify(t, sh_trip[8*ch +: 8], sh_delay[8*ch +: 8], m_tcnt[ch], m_tlatch[ch]);
        end
        en = sh_en[ch];
        st.ch    = ch;
        st.temp  = en ? m_temp[ch] : 8'd0;
        st.alarm = en & m_alatch[ch];
        st.trip  = en & m_tlatch[ch];
        st.fault = en ? m_fault[ch] : 8'd0;
        st.oor   = en & m_range[ch];
    endtask

    // call at a rising edge; returns at the edge the beat is taken
    task automatic send_beat(input bit act, input logic [1:0] ch, input logic [7:0] fs,
                             input logic [14:0] code, input bit fbit);
        int      gap;
        t_status st;
        gap = src_idle ? $urandom_range(0, 18) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_channel    <= ch;
        i_fault_byte <= fs;
        i_code_high  <= code[14:7];
        i_code_low   <= {code[6:0], fbit};
        do @(posedge i_clk); while (o_ready !== 1'b1);
        apply_sample(act, ch, fs, code, fbit, st);
        status_q.push_back(st);
    endtask

    task automatic all_results_in;
        i_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] alarm, input logic [31:0] trip,
                              input logic [31:0] dly, input logic [3:0] en);
        cfg_write(CFG_ALARM_LIMITS, alarm);
        cfg_write(CFG_TRIP_LIMITS, trip);
        cfg_write(CFG_DELAYS, dly);
        cfg_write(CFG_ENABLE_MASK, {28'd0, en});
        i_cfg_we <= 1'b0;
        sh_alarm = alarm;
        sh_trip  = trip;
        sh_delay = dly;
        sh_en    = en;
    endtask

    function automatic logic [31:0] short_delays();
        return {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
    endfunction

    task automatic send_random_item;
        int          r, c;
        bit          act, fbit;
        logic [1:0]  ch;
        logic [7:0]  fs, lim;
        logic [14:0] code;
        r    = $urandom_range(0, 99);
        ch   = 2'($urandom_range(0, 3));
        act  = r < 4;
        fs   = (r >= 4 && r < 14) ? 8'($urandom_range(1, 255)) : 8'd0;
        fbit = $urandom_range(0, 99) < 8;
        r    = $urandom_range(0, 9);
        if (r < 2) begin
            code = 15'($urandom_range(0, 32767));
        end else if (r < 6) begin
            // hover around the limit of this channel
            lim = $urandom_range(0, 1) ? sh_alarm[8*ch +: 8] : sh_trip[8*ch +: 8];
            c = int'(code_for_temp(lim)) + int'($urandom_range(0, 60)) - 30;
            if (c < 0) c = 0;
            code = 15'(c);
        end else begin
            code = 15'($urandom_range(8000, 16200));
        end
        send_beat(act, ch, fs, code, fbit);
    endtask

    always @(posedge i_clk) begin : result_check
        t_status got, want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            got = {o_report_channel, o_temperature, o_alarm, o_trip,
                   o_fault_code, o_out_of_range};
            if (status_q.size() == 0) begin
                log_error({"result with nothing pending: ", show_status(got)});
            end else begin
                want = status_q.pop_front();
                if (got !== want)
                    log_error({"expected ", show_status(want), " got ", show_status(got)});
            end
            sink_wait = sink_idle ? $urandom_range(0, 18) : 0;
        end
        if (hold_on) begin
            i_ready <= 1'b0;
        end else if (sink_wait != 0) begin
            sink_wait = sink_wait - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // defaults: every channel disabled, reports read zero
    task automatic test_reset_state;
        send_beat(0, 2'd0, 8'd0, code_for_temp(8'd150), 0);
        send_beat(0, 2'd1, 8'h80, 15'h4000, 0);
        send_beat(0, 2'd2, 8'd0, 15'h2100, 1);
        send_beat(1, 2'd3, 8'd0, 15'd0, 0);
        all_results_in();
    endtask

    task automatic test_directed;
        logic [14:0] c70;
        c70 = code_for_temp(8'd70);
        // alarm 100/50/255/0, trip 110/60/255/0, delay 2 on ch1 only
        set_config(32'h00FF_3264, 32'h00FF_3C6E, 32'h0000_0200, 4'hF);
        send_beat(0, 2'd0, 8'd0, 15'd0, 0);                   // below R0
        send_beat(0, 2'd0, 8'd0, 15'h7FFF, 0);                // clamps to 255
        send_beat(0, 2'd2, 8'd0, code_for_temp(8'd255) - 15'd1, 0);
        send_beat(0, 2'd2, 8'd0, code_for_temp(8'd255), 0);
        send_beat(1, 2'd0, 8'hA5, 15'h5A5A, 1);               // clear all latches
        send_beat(0, 2'd0, 8'd0, code_for_temp(8'd100) - 15'd1, 0);
        send_beat(0, 2'd0, 8'd0, code_for_temp(8'd100), 0);   // exactly at limit
        send_beat(0, 2'd3, 8'd0, 15'h1234, 1);                // code fault bit, limit 0
        send_beat(0, 2'd3, 8'hFF, 15'h7FFF, 0);
        send_beat(0, 2'd3, 8'h01, 15'd0, 1);
        send_beat(0, 2'd3, 8'd0, code_for_temp(8'd20), 0);
        repeat (3) send_beat(0, 2'd1, 8'd0, c70, 0);          // latches on the third
        send_beat(1, 2'd1, 8'd0, 15'd0, 0);
        send_beat(0, 2'd1, 8'd0, c70, 0);
        send_beat(0, 2'd1, 8'd0, code_for_temp(8'd49), 0);    // count restarts
        send_beat(0, 2'd1, 8'd0, c70, 0);
        send_beat(0, 2'd1, 8'd0, c70, 0);
        all_results_in();
        // disabled channels still update their state
        set_config(32'h00FF_3264, 32'h00FF_3C6E, 32'h0000_0200, 4'h5);
        send_beat(0, 2'd1, 8'd0, c70, 0);
        send_beat(0, 2'd0, 8'd0, code_for_temp(8'd120), 0);
        send_beat(0, 2'd3, 8'h40, 15'd0, 0);
        all_results_in();
        set_config(32'h00FF_3264, 32'h00FF_3C6E, 32'h0000_0200, 4'hF);
        send_beat(0, 2'd1, 8'h02, 15'd0, 0);                  // fault keeps the latches
        send_beat(0, 2'd3, 8'd0, 15'd0, 0);
        all_results_in();
    endtask

    task automatic test_random_phases;
        for (int p = 0; p < 5; p++) begin
            src_idle  = (p % 3) != 1;
            sink_idle = (p % 3) != 2;
            case (p)
                0: set_config($urandom, $urandom, 32'h0, 4'hF);
                1: set_config(32'h0, 32'hFFFF_FFFF, short_delays(), 4'($urandom_range(0, 15)));
                2: set_config($urandom, $urandom, 32'hFFFF_FFFF, 4'hF);
                default: set_config($urandom, $urandom, short_delays(),
                                    4'($urandom_range(1, 15)));
            endcase
            for (int n = 0; n < 320; n++) send_random_item();
            all_results_in();
        end
    endtask

    // result side blocked for a long stretch while beats keep coming
    task automatic test_backpressure;
        src_idle  = 1'b0;
        sink_idle = 1'b1;
        set_config($urandom, $urandom, short_delays(), 4'hF);
        fork
            begin
                hold_on <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_on <= 1'b0;
            end
            begin
                for (int n = 0; n < 80; n++) send_random_item();
            end
        join
        all_results_in();
    endtask

    task automatic test_pause_resume;
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        for (int n = 0; n < 30; n++) send_random_item();
        all_results_in();
        for (int n = 0; n < 30; n++) send_random_item();
        all_results_in();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_directed();
        test_random_phases();
        test_backpressure();
        test_pause_resume();
        all_results_in();
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
